// ----- src/sprsel_pkg.sv -----
// Shared types and constants for the scanline sprite selector.
// Used by sprsel_attr_mem, sprsel_ctrl and the top level; depends on nothing.

package sprsel_pkg;

    // Widths of one attribute entry and of its address.
    localparam int BYTE_W = 8;
    localparam int WORD_W = 32;
    localparam int ADDR_W = 6;

    // Sprite geometry.
    localparam logic [8:0] Y_OFFSET      = 9'd16;
    localparam logic [8:0] HEIGHT_SHORT  = 9'd8;
    localparam logic [8:0] HEIGHT_TALL   = 9'd16;
    localparam logic [7:0] TALL_TILE_MSK = 8'hFE;

    // Operation codes on the op port.
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_SCAN  = 2'd2
    } op_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    // One access to the attribute memory.
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        logic [1:0]        byte_sel;
        logic [BYTE_W-1:0] wdata;
    } mem_req_t;

endpackage

// ----- src/sprsel_attr_mem.sv -----
// Attribute memory: one 32-bit word per entry (y, x, tile, flags in byte lanes 0..3).
// Per-entry valid bits make unwritten entries read as zero. Depends on sprsel_pkg.

module sprsel_attr_mem #(
    parameter int ENTRY_COUNT = 40
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sprsel_pkg::mem_req_t                req,
    output logic [sprsel_pkg::WORD_W-1:0]       rd_word
);

    localparam int EW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

    logic [sprsel_pkg::WORD_W-1:0] mem [ENTRY_COUNT];
    logic [ENTRY_COUNT-1:0]        valid_reg;
    logic [sprsel_pkg::WORD_W-1:0] rd_data_reg;
    logic                          rd_valid_reg;
    logic [EW-1:0]                 index;

    assign index = req.addr[EW-1:0];

    // Byte write; the first write to an entry also zeroes its other lanes.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            if (valid_reg[index])
            begin
                mem[index][{req.byte_sel, 3'b000} +: sprsel_pkg::BYTE_W] <= req.wdata;
            end
            else
            begin
                mem[index] <= sprsel_pkg::WORD_W'(req.wdata) << {req.byte_sel, 3'b000};
            end
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[index];
        end
    end

    // Valid bits are cleared at reset and set by the first write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[index] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[index];
            end
        end
    end

    assign rd_word = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ----- src/sprsel_ctrl.sv -----
// Sequencer: decodes items, walks the attribute memory one entry a cycle during a scan,
// and drives the result registers. Depends on sprsel_pkg.

module sprsel_ctrl #(
    parameter int ENTRY_COUNT  = 40,
    parameter int MAX_PER_LINE = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [1:0]                       op,
    input  logic [7:0]                       byte_index,
    input  logic [7:0]                       write_data,
    input  logic [7:0]                       scan_line,
    input  logic                             tall_sprites,
    input  logic [sprsel_pkg::WORD_W-1:0]    rd_word,
    output sprsel_pkg::mem_req_t             req,
    output logic                             busy,
    output logic                             done,
    output logic [7:0]                       read_data,
    output logic                             found,
    output logic [3:0]                       slot,
    output logic [5:0]                       entry_number,
    output logic [7:0]                       sprite_y,
    output logic [7:0]                       sprite_x,
    output logic [7:0]                       sprite_tile,
    output logic [7:0]                       sprite_flags,
    output logic                             last
);

    localparam int EW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int CW = $clog2(MAX_PER_LINE + 1);
    localparam logic [8:0] MEM_BYTES = 9'(4 * ENTRY_COUNT);

    sprsel_pkg::state_t state_reg, state_next;

    logic [EW-1:0]                 ev_reg;
    logic [CW-1:0]                 cnt_reg;
    logic [8:0]                    target_reg;
    logic [1:0]                    sel_reg;
    logic                          oob_reg;
    logic [sprsel_pkg::WORD_W-1:0] pend_word_reg;
    logic [EW-1:0]                 pend_entry_reg;

    logic                          done_reg;
    logic [7:0]                    read_data_reg;
    logic                          found_reg;
    logic [3:0]                    slot_reg;
    logic [5:0]                    entry_reg;
    logic [sprsel_pkg::WORD_W-1:0] sprite_word_reg;
    logic                          last_reg;

    logic                          accept;
    logic                          in_range;
    logic [EW-1:0]                 ev_inc;
    logic                          ev_last;
    logic [7:0]                    cur_y;
    logic [7:0]                    cur_x;
    logic [7:0]                    cur_tile;
    logic [7:0]                    cur_flags;
    logic [8:0]                    height;
    logic                          hit;
    logic                          scan_end;
    logic                          emit_pend;
    logic [sprsel_pkg::WORD_W-1:0] lane_shift;

    assign accept   = start && (state_reg == sprsel_pkg::ST_IDLE);
    assign in_range = {1'b0, byte_index} < MEM_BYTES;
    assign ev_inc   = ev_reg + EW'(1);
    assign ev_last  = ev_reg == EW'(ENTRY_COUNT - 1);

    // Entry under test: nonzero x and cover check against line + 16 without wrap.
    always_comb
    begin
        cur_y     = rd_word[7:0];
        cur_x     = rd_word[15:8];
        cur_tile  = rd_word[23:16];
        cur_flags = rd_word[31:24];
        height    = tall_sprites ? sprsel_pkg::HEIGHT_TALL : sprsel_pkg::HEIGHT_SHORT;
        hit       = (cur_x != 8'd0) && ({1'b0, cur_y} <= target_reg)
                    && (target_reg < ({1'b0, cur_y} + height));
        scan_end  = ev_last || (hit && (cnt_reg == CW'(MAX_PER_LINE - 1)));
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sprsel_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == sprsel_pkg::OP_READ)
                    begin
                        state_next = sprsel_pkg::ST_READ;
                    end
                    else if (op == sprsel_pkg::OP_SCAN)
                    begin
                        state_next = sprsel_pkg::ST_SCAN;
                    end
                end
            end
            sprsel_pkg::ST_READ:
            begin
                state_next = sprsel_pkg::ST_IDLE;
            end
            sprsel_pkg::ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = sprsel_pkg::ST_FLUSH;
                end
            end
            sprsel_pkg::ST_FLUSH:
            begin
                state_next = sprsel_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sprsel_pkg::ST_IDLE;
            end
        endcase
    end

    // Memory requests, busy and emit controls per state.
    always_comb
    begin
        req       = '0;
        emit_pend = 1'b0;
        busy      = 1'b1;
        case (state_reg)
            sprsel_pkg::ST_IDLE:
            begin
                busy         = 1'b0;
                req.addr     = byte_index[7:2];
                req.byte_sel = byte_index[1:0];
                req.wdata    = write_data;
                if (accept)
                begin
                    case (op)
                        sprsel_pkg::OP_WRITE: req.wr_en = in_range;
                        sprsel_pkg::OP_READ:  req.rd_en = in_range;
                        sprsel_pkg::OP_SCAN:
                        begin
                            req.rd_en = 1'b1;
                            req.addr  = '0;
                        end
                        default: req = '0;
                    endcase
                end
            end
            sprsel_pkg::ST_SCAN:
            begin
                req.rd_en = !ev_last;
                req.addr  = sprsel_pkg::ADDR_W'(ev_inc);
                emit_pend = hit && (cnt_reg != '0);
            end
            default:
            begin
                req = '0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sprsel_pkg::ST_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            case (state_reg)
                sprsel_pkg::ST_IDLE:
                begin
                    cnt_reg <= '0;
                end
                sprsel_pkg::ST_READ:
                begin
                    done_reg <= 1'b1;
                end
                sprsel_pkg::ST_SCAN:
                begin
                    if (hit)
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                    done_reg <= emit_pend;
                end
                sprsel_pkg::ST_FLUSH:
                begin
                    done_reg <= 1'b1;
                end
                default:
                begin
                    done_reg <= 1'b0;
                end
            endcase
        end
    end

    assign lane_shift = rd_word >> {sel_reg, 3'b000};

    // Item context, pending sprite and result payload.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            sprsel_pkg::ST_IDLE:
            begin
                ev_reg     <= '0;
                target_reg <= {1'b0, scan_line} + sprsel_pkg::Y_OFFSET;
                sel_reg    <= byte_index[1:0];
                oob_reg    <= !in_range;
            end
            sprsel_pkg::ST_READ:
            begin
                read_data_reg   <= oob_reg ? 8'd0 : lane_shift[7:0];
                found_reg       <= 1'b0;
                slot_reg        <= '0;
                entry_reg       <= '0;
                sprite_word_reg <= '0;
                last_reg        <= 1'b1;
            end
            sprsel_pkg::ST_SCAN:
            begin
                ev_reg <= ev_inc;
                if (hit)
                begin
                    pend_word_reg  <= {cur_flags,
                                       tall_sprites ? (cur_tile & sprsel_pkg::TALL_TILE_MSK)
                                                    : cur_tile,
                                       cur_x, cur_y};
                    pend_entry_reg <= ev_reg;
                end
                // A new hit pushes the previous one out as a non-final result.
                if (emit_pend)
                begin
                    read_data_reg   <= 8'd0;
                    found_reg       <= 1'b1;
                    slot_reg        <= 4'(cnt_reg - CW'(1));
                    entry_reg       <= 6'(pend_entry_reg);
                    sprite_word_reg <= pend_word_reg;
                    last_reg        <= 1'b0;
                end
            end
            sprsel_pkg::ST_FLUSH:
            begin
                read_data_reg <= 8'd0;
                last_reg      <= 1'b1;
                if (cnt_reg != '0)
                begin
                    found_reg       <= 1'b1;
                    slot_reg        <= 4'(cnt_reg - CW'(1));
                    entry_reg       <= 6'(pend_entry_reg);
                    sprite_word_reg <= pend_word_reg;
                end
                else
                begin
                    found_reg       <= 1'b0;
                    slot_reg        <= '0;
                    entry_reg       <= '0;
                    sprite_word_reg <= '0;
                end
            end
            default:
            begin
                last_reg <= 1'b1;
            end
        endcase
    end

    assign done         = done_reg;
    assign read_data    = read_data_reg;
    assign found        = found_reg;
    assign slot         = slot_reg;
    assign entry_number = entry_reg;
    assign sprite_y     = sprite_word_reg[7:0];
    assign sprite_x     = sprite_word_reg[15:8];
    assign sprite_tile  = sprite_word_reg[23:16];
    assign sprite_flags = sprite_word_reg[31:24];
    assign last         = last_reg;

endmodule

// ----- src/scanline_sprite_selector_core.sv -----
// Top level of the scanline sprite selector: configuration register and wiring.
// Depends on sprsel_pkg, sprsel_attr_mem and sprsel_ctrl.

// An item is taken when start is high and busy is low. A write gives no result and leaves
// the block idle, so the next item may follow at once. A read gives its single result on
// done, registered from the memory word in ST_READ. A scan reads one attribute entry per
// cycle through the memory's single read port and stops early when MAX_PER_LINE sprites
// are found; selected sprites appear on done as the walk proceeds and the final transfer,
// marked by last, comes from ST_FLUSH after the last entry checked. Each result is shown
// for exactly one cycle and cannot be held off, so the receiver must take every transfer
// when done is high. The attribute memory reads as zero after reset with no clearing pass.
// tall_sprites is written through config_write and config_data; the user must write it
// only while the block is idle, as the block does not enforce this.

module scanline_sprite_selector_core #(
    parameter int ENTRY_COUNT  = 40,
    parameter int MAX_PER_LINE = 10
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       config_write,
    input  logic       config_data,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] op,
    input  logic [7:0] byte_index,
    input  logic [7:0] write_data,
    input  logic [7:0] scan_line,
    output logic       done,
    output logic [7:0] read_data,
    output logic       found,
    output logic [3:0] slot,
    output logic [5:0] entry_number,
    output logic [7:0] sprite_y,
    output logic [7:0] sprite_x,
    output logic [7:0] sprite_tile,
    output logic [7:0] sprite_flags,
    output logic       last
);

    logic                          tall_sprites_reg;
    sprsel_pkg::mem_req_t          req;
    logic [sprsel_pkg::WORD_W-1:0] rd_word;

    // Sprite height register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tall_sprites_reg <= 1'b0;
        end
        else if (config_write)
        begin
            tall_sprites_reg <= config_data;
        end
    end

    sprsel_attr_mem #(
        .ENTRY_COUNT (ENTRY_COUNT)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_word (rd_word)
    );

    sprsel_ctrl #(
        .ENTRY_COUNT  (ENTRY_COUNT),
        .MAX_PER_LINE (MAX_PER_LINE)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .op           (op),
        .byte_index   (byte_index),
        .write_data   (write_data),
        .scan_line    (scan_line),
        .tall_sprites (tall_sprites_reg),
        .rd_word      (rd_word),
        .req          (req),
        .busy         (busy),
        .done         (done),
        .read_data    (read_data),
        .found        (found),
        .slot         (slot),
        .entry_number (entry_number),
        .sprite_y     (sprite_y),
        .sprite_x     (sprite_x),
        .sprite_tile  (sprite_tile),
        .sprite_flags (sprite_flags),
        .last         (last)
    );

endmodule

// ----- src/sprsel_checker.sv -----
// Port-level checks for scanline_sprite_selector_core, attached by the bind below.
// Depends only on the top level's ports.

module sprsel_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [7:0] read_data,
    input logic       found,
    input logic [7:0] sprite_x,
    input logic       last
);

    // Only the final transfer of an item may carry no sprite.
    assert property (@(posedge clk) disable iff (!rst_n) done && !last |-> found)
        else $error("non-final transfer without a sprite");

    // A sprite transfer never carries read data, and its x byte is nonzero.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && found |-> (read_data == 8'd0) && (sprite_x != 8'd0))
        else $error("sprite transfer with bad payload");

    // A transfer never appears the cycle after an item is taken.
    assert property (@(posedge clk) disable iff (!rst_n) start && !busy |=> !done)
        else $error("transfer right after item was taken");

    // The block is free again once the final transfer shows.
    assert property (@(posedge clk) disable iff (!rst_n) done && last |-> !busy)
        else $error("busy during final transfer");

    // A scan still in progress keeps busy high.
    assert property (@(posedge clk) disable iff (!rst_n) done && !last |-> busy)
        else $error("idle while a scan is still emitting");

endmodule

bind scanline_sprite_selector_core sprsel_checker u_sprsel_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .read_data (read_data),
    .found     (found),
    .sprite_x  (sprite_x),
    .last      (last)
);
